// ===== hw/rtl/channel_command_stream_parser_defines.svh =====
// ----------------------------------------------------------------------------
// channel_command_stream_parser_defines.svh
// Assertion macros used by the command stream parser checker.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_COMMAND_STREAM_PARSER_DEFINES_SVH
`define CHANNEL_COMMAND_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define CCSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ccsp: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define CCSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ccsp: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define CCSP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("ccsp: reset check failed");

`endif

// ===== hw/rtl/ccsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsp_pkg
// Widths, header codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
package ccsp_pkg;

    localparam int WORD_W    = 32;
    localparam int OFS_W     = 12;
    localparam int METHOD_W  = 12;
    localparam int CLASS_W   = 10;
    localparam int MASK_W    = 16;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = $clog2(MASK_W);
    localparam int MODE_W    = 4;
    localparam int MODE_LSB  = 28;
    localparam int OFS_LSB   = 16;
    localparam int VAL_W     = 16;
    localparam int IMM_W     = 12;
    localparam int SC_MASK_W = 6;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_SET_CLASS = 4'd0;
    localparam mode_t MODE_INCR      = 4'd1;
    localparam mode_t MODE_NONINCR   = 4'd2;
    localparam mode_t MODE_MASK      = 4'd3;
    localparam mode_t MODE_IMM       = 4'd4;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_MASK_DATA,
        CMD_COUNT_DATA,
        CMD_SET_CLASS,
        CMD_INCR,
        CMD_NONINCR,
        CMD_MASK,
        CMD_IMM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   bit_idx;
        logic [WORD_W-1:0]  word;
    } cmd_t;

endpackage

// ===== hw/rtl/ccsp_front.sv =====
// ----------------------------------------------------------------------------
// ccsp_front
// Accepts stream words, tracks what is pending and classifies each word.
// ----------------------------------------------------------------------------
module ccsp_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ccsp_pkg::WORD_W-1:0] s_word,
    input  logic                     q_full,
    output logic                     q_push,
    output ccsp_pkg::cmd_t           q_cmd
);

    logic [ccsp_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [ccsp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ccsp_pkg::IDX_W-1:0]  low_idx;
    ccsp_pkg::mode_t             mode;
    logic                        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign mode    = s_word[ccsp_pkg::MODE_LSB +: ccsp_pkg::MODE_W];

    // priority encoder, lowest set bit wins
    always_comb begin
        low_idx = '0;
        for (int i = ccsp_pkg::MASK_W - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_idx = ccsp_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        mask_next       = mask_reg;
        count_next      = count_reg;
        q_cmd.kind      = ccsp_pkg::CMD_NOP;
        q_cmd.bit_idx   = low_idx;
        q_cmd.word      = s_word;
        if (mask_reg != '0) begin
            q_cmd.kind = ccsp_pkg::CMD_MASK_DATA;
            if (accept) begin
                mask_next[low_idx] = 1'b0;
            end
        end else if (count_reg != '0) begin
            q_cmd.kind = ccsp_pkg::CMD_COUNT_DATA;
            if (accept) begin
                count_next = count_reg - 1'b1;
            end
        end else begin
            case (mode)
                ccsp_pkg::MODE_SET_CLASS: begin
                    q_cmd.kind = ccsp_pkg::CMD_SET_CLASS;
                    if (accept) begin
                        mask_next = ccsp_pkg::MASK_W'(s_word[ccsp_pkg::SC_MASK_W-1:0]);
                    end
                end
                ccsp_pkg::MODE_INCR: begin
                    q_cmd.kind = ccsp_pkg::CMD_INCR;
                    if (accept) begin
                        count_next = s_word[ccsp_pkg::VAL_W-1:0];
                    end
                end
                ccsp_pkg::MODE_NONINCR: begin
                    q_cmd.kind = ccsp_pkg::CMD_NONINCR;
                    if (accept) begin
                        count_next = s_word[ccsp_pkg::VAL_W-1:0];
                    end
                end
                ccsp_pkg::MODE_MASK: begin
                    q_cmd.kind = ccsp_pkg::CMD_MASK;
                    if (accept) begin
                        mask_next = s_word[ccsp_pkg::VAL_W-1:0];
                    end
                end
                ccsp_pkg::MODE_IMM: begin
                    q_cmd.kind = ccsp_pkg::CMD_IMM;
                end
                default: begin
                    q_cmd.kind = ccsp_pkg::CMD_NOP;
                end
            endcase
        end
    end

    // unknown headers are dropped here and never reach the back end
    assign q_push = accept && (q_cmd.kind != ccsp_pkg::CMD_NOP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            count_reg <= '0;
        end else begin
            mask_reg  <= mask_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ccsp_queue.sv =====
// ----------------------------------------------------------------------------
// ccsp_queue
// Short command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module ccsp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ccsp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output ccsp_pkg::cmd_t q_cmd
);

    ccsp_pkg::cmd_t                mem [ccsp_pkg::QDEPTH];
    logic [ccsp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ccsp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ccsp_pkg::QPTR_W:0]     count_reg, count_next;
    logic                          do_push, do_pop;

    assign full    = (count_reg == (ccsp_pkg::QPTR_W + 1)'(ccsp_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ccsp_pkg::QPTR_W'(ccsp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ccsp_pkg::QPTR_W'(ccsp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ccsp_back.sv =====
// ----------------------------------------------------------------------------
// ccsp_back
// Executes classified commands: offset and class state, method write output.
// ----------------------------------------------------------------------------
module ccsp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ccsp_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ccsp_pkg::CLASS_W-1:0]  m_target_class,
    output logic [ccsp_pkg::METHOD_W-1:0] m_method,
    output logic [ccsp_pkg::WORD_W-1:0]   m_payload
);

    logic [ccsp_pkg::OFS_W-1:0]    base_reg, base_next;
    logic                          auto_inc_reg, auto_inc_next;
    logic [ccsp_pkg::CLASS_W-1:0]  class_reg, class_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ccsp_pkg::CLASS_W-1:0]  m_class_reg, m_class_next;
    logic [ccsp_pkg::METHOD_W-1:0] m_method_reg, m_method_next;
    logic [ccsp_pkg::WORD_W-1:0]   m_payload_reg, m_payload_next;
    logic [ccsp_pkg::OFS_W-1:0]    hdr_ofs;
    logic [ccsp_pkg::OFS_W-1:0]    mask_method;

    // output register free or draining this cycle
    assign q_pop       = q_valid && (!m_valid_reg || m_ready);
    assign hdr_ofs     = q_cmd.word[ccsp_pkg::OFS_LSB +: ccsp_pkg::OFS_W];
    assign mask_method = base_reg + ccsp_pkg::OFS_W'(q_cmd.bit_idx);

    always_comb begin
        base_next      = base_reg;
        auto_inc_next  = auto_inc_reg;
        class_next     = class_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_class_next   = m_class_reg;
        m_method_next  = m_method_reg;
        m_payload_next = m_payload_reg;
        if (q_pop) begin
            case (q_cmd.kind)
                ccsp_pkg::CMD_MASK_DATA: begin
                    m_valid_next   = 1'b1;
                    m_class_next   = class_reg;
                    m_method_next  = ccsp_pkg::METHOD_W'(mask_method);
                    m_payload_next = q_cmd.word;
                end
                ccsp_pkg::CMD_COUNT_DATA: begin
                    m_valid_next   = 1'b1;
                    m_class_next   = class_reg;
                    m_method_next  = ccsp_pkg::METHOD_W'(base_reg);
                    m_payload_next = q_cmd.word;
                    if (auto_inc_reg) begin
                        base_next = base_reg + 1'b1;
                    end
                end
                ccsp_pkg::CMD_SET_CLASS: begin
                    base_next  = hdr_ofs;
                    class_next = q_cmd.word[ccsp_pkg::SC_MASK_W +: ccsp_pkg::CLASS_W];
                end
                ccsp_pkg::CMD_INCR: begin
                    base_next     = hdr_ofs;
                    auto_inc_next = 1'b1;
                end
                ccsp_pkg::CMD_NONINCR: begin
                    base_next     = hdr_ofs;
                    auto_inc_next = 1'b0;
                end
                ccsp_pkg::CMD_MASK: begin
                    base_next = hdr_ofs;
                end
                ccsp_pkg::CMD_IMM: begin
                    base_next      = hdr_ofs;
                    m_valid_next   = 1'b1;
                    m_class_next   = class_reg;
                    m_method_next  = ccsp_pkg::METHOD_W'(hdr_ofs);
                    m_payload_next = ccsp_pkg::WORD_W'(q_cmd.word[ccsp_pkg::IMM_W-1:0]);
                end
                default: begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            auto_inc_reg <= 1'b0;
            class_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            base_reg     <= base_next;
            auto_inc_reg <= auto_inc_next;
            class_reg    <= class_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_class_reg   <= m_class_next;
        m_method_reg  <= m_method_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_target_class = m_class_reg;
    assign m_method       = m_method_reg;
    assign m_payload      = m_payload_reg;

endmodule

// ===== hw/rtl/channel_command_stream_parser.sv =====
// An accepted word passes through the command queue and the output register before its method write shows on m_valid.
// One word per cycle, sustained while m_ready stays high.
// The two-entry command queue lets the front keep accepting while a result waits.
// Reset (aresetn low, synchronous) clears pending mask/count, base offset,
// increment mode, selected class, the queue and the output valid.
// ----------------------------------------------------------------------------
// channel_command_stream_parser
// Command stream parser: headers load state, data words become method writes.
// ----------------------------------------------------------------------------
module channel_command_stream_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ccsp_pkg::WORD_W-1:0]   s_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ccsp_pkg::CLASS_W-1:0]  m_target_class,
    output logic [ccsp_pkg::METHOD_W-1:0] m_method,
    output logic [ccsp_pkg::WORD_W-1:0]   m_payload
);

    ccsp_pkg::cmd_t push_cmd;
    ccsp_pkg::cmd_t head_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;

    ccsp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_full  (full),
        .q_push  (push),
        .q_cmd   (push_cmd)
    );

    ccsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .q_valid  (head_valid),
        .q_cmd    (head_cmd)
    );

    ccsp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (head_valid),
        .q_cmd          (head_cmd),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_target_class (m_target_class),
        .m_method       (m_method),
        .m_payload      (m_payload)
    );

endmodule

// ===== hw/rtl/ccsp_checker.sv =====
// ----------------------------------------------------------------------------
// ccsp_checker
// Port-level checks on the command stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "channel_command_stream_parser_defines.svh"

module ccsp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [ccsp_pkg::WORD_W-1:0]   s_word,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ccsp_pkg::CLASS_W-1:0]  m_target_class,
    input  logic [ccsp_pkg::METHOD_W-1:0] m_method,
    input  logic [ccsp_pkg::WORD_W-1:0]   m_payload
);

    // an offered word holds until taken
    `CCSP_ASSERT_NEXT(a_input_hold, s_valid && !s_ready, s_valid && $stable(s_word))

    // a stalled result holds
    `CCSP_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_target_class) && $stable(m_method) && $stable(m_payload))

    // reset empties the output and the queue
    `CCSP_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_valid && s_ready)

    // with the sink always ready the queue drains, so input is never throttled
    `CCSP_ASSERT_SAME(a_no_throttle, $past(m_ready, 1) && $past(m_ready, 2) && $past(aresetn, 2), s_ready)

endmodule

bind channel_command_stream_parser ccsp_checker u_ccsp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_word         (s_word),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_target_class (m_target_class),
    .m_method       (m_method),
    .m_payload      (m_payload)
);

// ===== tb/channel_command_stream_parser_test.sv =====
// ----------------------------------------------------------------------------
// channel_command_stream_parser_test
// Self-checking bench for the command stream parser. A queue of command words
// (headers followed by their data, plus noise and cut-short sequences) is fed
// through a bursty valid/ready driver. A word-level parser model predicts
// every method write, and the monitor checks each one against it under a
// randomly stalling receiver that includes one long hold-off.
// ----------------------------------------------------------------------------
module channel_command_stream_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ccsp_pkg::*;

    localparam int UNUSED_MODE_LO = MODE_IMM + 1;
    localparam int UNUSED_MODE_HI = 2**MODE_W - 1;
    localparam int RANDOM_WORDS   = 1300;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [METHOD_W-1:0] meth;
        logic [WORD_W-1:0]   data;
    } method_write_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_style_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [WORD_W-1:0]   s_word  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CLASS_W-1:0]  m_target_class;
    logic [METHOD_W-1:0] m_method;
    logic [WORD_W-1:0]   m_payload;

    logic [WORD_W-1:0] cmd_words[$];
    method_write_t     method_writes_due[$];

    // parser model state
    logic [MASK_W-1:0]  mask_left   = '0;
    logic [CNT_W-1:0]   count_left  = '0;
    logic [OFS_W-1:0]   method_base = '0;
    logic               auto_inc    = 1'b0;
    logic [CLASS_W-1:0] cur_class   = '0;

    int        fail_count     = 0;
    int        words_accepted = 0;
    int        writes_checked = 0;
    logic      word_taken     = 1'b0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        hold_left      = 0;
    logic      hold_used      = 1'b0;
    int        phase_left     = 0;
    rx_style_t rx_style       = RX_OPEN;

    channel_command_stream_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word         (s_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_target_class (m_target_class),
        .m_method       (m_method),
        .m_payload      (m_payload)
    );

    always #2 aclk = ~aclk;

    function automatic logic [WORD_W-1:0] make_header(mode_t m, logic [OFS_W-1:0] ofs,
                                                       logic [VAL_W-1:0] val);
        return {m, ofs, val};
    endfunction

    function automatic logic [WORD_W-1:0] rand_data();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OFS_W-1:0] rand_ofs();
        // bias toward the top of the range so offsets wrap often
        if ($urandom_range(0, 3) == 0) return OFS_W'($urandom_range(12'hff0, 12'hfff));
        return OFS_W'($urandom);
    endfunction

    task automatic add_data(int n);
        repeat (n) cmd_words.push_back(rand_data());
    endtask

    // Advance the parser model by one word; queue the method write it causes.
    task automatic decode_word(logic [WORD_W-1:0] w);
        mode_t            mode;
        logic [OFS_W-1:0] ofs;
        logic [VAL_W-1:0] val;
        int               idx;
        mode = w[MODE_LSB +: MODE_W];
        ofs  = w[OFS_LSB +: OFS_W];
        val  = w[VAL_W-1:0];
        if (mask_left != '0) begin
            idx = 0;
            while (!mask_left[idx]) idx++;
            mask_left[idx] = 1'b0;
            method_writes_due.push_back(method_write_t'{cur_class,
                                                        method_base + OFS_W'(idx), w});
        end else if (count_left != '0) begin
            count_left = count_left - 1'b1;
            method_writes_due.push_back(method_write_t'{cur_class, method_base, w});
            if (auto_inc) method_base = method_base + 1'b1;
        end else begin
            case (mode)
                MODE_SET_CLASS: begin
                    mask_left   = MASK_W'(val[SC_MASK_W-1:0]);
                    method_base = ofs;
                    cur_class   = val[VAL_W-1 -: CLASS_W];
                end
                MODE_INCR, MODE_NONINCR: begin
                    count_left  = val;
                    method_base = ofs;
                    auto_inc    = (mode == MODE_INCR);
                end
                MODE_MASK: begin
                    mask_left   = val;
                    method_base = ofs;
                end
                MODE_IMM: begin
                    method_base = ofs;
                    method_writes_due.push_back(method_write_t'{cur_class, ofs,
                                                                WORD_W'(val[IMM_W-1:0])});
                end
                default: ;
            endcase
        end
    endtask

    function automatic void check_field(string name, logic [WORD_W-1:0] exp,
                                        logic [WORD_W-1:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            fail_count++;
        end
    endfunction

    // driver: bursts of transactions separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !word_taken) begin
            // hold the offered word until it is taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid  <= 1'b0;
        end else if (cmd_words.size() > 0) begin
            s_valid <= 1'b1;
            s_word  <= cmd_words.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: phases of open, random and sparse ready, plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_used && words_accepted >= HOLD_AFTER) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_style   <= rx_style_t'($urandom_range(0, 2));
                phase_left <= $urandom_range(10, 80);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: model input transactions, check output transactions
    always @(posedge aclk) begin
        method_write_t due;
        word_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            decode_word(s_word);
            words_accepted++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (method_writes_due.size() == 0) begin
                $error("unexpected method write: class %0h method %0h payload %0h",
                       m_target_class, m_method, m_payload);
                fail_count++;
            end else begin
                due = method_writes_due.pop_front();
                check_field("target_class", WORD_W'(due.cls), WORD_W'(m_target_class));
                check_field("method", WORD_W'(due.meth), WORD_W'(m_method));
                check_field("payload", due.data, m_payload);
                writes_checked++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int               pick;
        int               n;
        logic [VAL_W-1:0] v;

        // set-class with all-ones class and mask, offsets wrap past the top
        cmd_words.push_back(make_header(MODE_SET_CLASS, 12'hffe, 16'hffff));
        cmd_words.push_back(32'hffff_ffff);
        cmd_words.push_back(32'h0000_0000);
        cmd_words.push_back(32'h8000_0000);
        cmd_words.push_back(32'h0000_0001);
        cmd_words.push_back(32'h5a5a_5a5a);
        cmd_words.push_back(32'ha5a5_a5a5);
        // mask with lowest and highest bits only
        cmd_words.push_back(make_header(MODE_MASK, 12'hfff, 16'h8001));
        add_data(2);
        cmd_words.push_back(make_header(MODE_INCR, 12'hfff, 16'd2));
        add_data(2);
        cmd_words.push_back(make_header(MODE_NONINCR, 12'h000, 16'd2));
        add_data(2);
        // zero mask and zero count leave nothing pending
        cmd_words.push_back(make_header(MODE_MASK, 12'h123, 16'h0000));
        cmd_words.push_back(make_header(MODE_IMM, 12'habc, 16'hffff));
        cmd_words.push_back(make_header(MODE_INCR, 12'h456, 16'h0000));
        // unused header modes are dropped
        cmd_words.push_back(32'hffff_ffff);
        cmd_words.push_back({MODE_W'(UNUSED_MODE_LO), 28'h0000_000});
        cmd_words.push_back(make_header(MODE_SET_CLASS, 12'h000, 16'h0000));
        cmd_words.push_back(make_header(MODE_IMM, 12'h000, 16'h0000));

        while (cmd_words.size() < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                v = VAL_W'($urandom);
                if ($urandom_range(0, 3) == 0) v[SC_MASK_W-1:0] = '0;
                cmd_words.push_back(make_header(MODE_SET_CLASS, rand_ofs(), v));
                add_data($countones(v[SC_MASK_W-1:0]));
            end else if (pick < 45) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
                cmd_words.push_back(make_header($urandom_range(0, 1) ? MODE_INCR : MODE_NONINCR,
                                                rand_ofs(), VAL_W'(n)));
                add_data(n);
            end else if (pick < 65) begin
                v = ($urandom_range(0, 2) == 0) ? VAL_W'(1 << $urandom_range(0, 15))
                                                : VAL_W'($urandom);
                cmd_words.push_back(make_header(MODE_MASK, rand_ofs(), v));
                add_data($countones(v));
            end else if (pick < 80) begin
                cmd_words.push_back(make_header(MODE_IMM, rand_ofs(), VAL_W'($urandom)));
            end else if (pick < 90) begin
                cmd_words.push_back({MODE_W'($urandom_range(UNUSED_MODE_LO, UNUSED_MODE_HI)),
                                     28'($urandom)});
            end else if (pick < 95) begin
                // sequence cut short: following headers get consumed as data
                v = VAL_W'($urandom_range(1, 16'hffff));
                cmd_words.push_back(make_header(MODE_MASK, rand_ofs(), v));
                add_data($urandom_range(0, $countones(v) - 1));
            end else begin
                cmd_words.push_back($urandom);
            end
        end
        // long incrementing run across the offset wrap, left unfinished
        cmd_words.push_back(make_header(MODE_INCR, 12'hfe0, 16'hffff));
        add_data(48);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (cmd_words.size() != 0 || s_valid);
        while (method_writes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d command word transactions and %0d method writes,",
                 words_accepted, writes_checked);
        $display("with bursty input and a %0d-cycle output hold-off.", HOLD_CYCLES);
        if (fail_count == 0 && method_writes_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
